/* rtl/tlq_pkg.sv */
`default_nettype none
package tlq_pkg;

	// Direction components are scaled down until both fit in this many bits.
	localparam int NORM_BITS = 24;
	localparam int SQ_BITS   = 2 * NORM_BITS;
	// Square root radicand and root widths; radicand is (ax^2 + ay^2) << RAD_SHIFT.
	localparam int RAD_BITS  = 64;
	localparam int ROOT_BITS = 32;
	localparam int RAD_SHIFT = 14;
	// Quotient headroom above FRAC_BITS: |n| stays near line_width / 2.
	localparam int QUOT_XTRA = 9;

	localparam logic [2:0] VIDX_FIRST = 3'd0;
	localparam logic [2:0] VIDX_LAST  = 3'd5;

	typedef struct packed {
		logic degen;
		logic dx_neg;
		logic dy_neg;
	} tlq_flags_t;

	// Quad vertex order: p1+n, p1-n, p2-n, p2+n, p1+n, p2-n
	function automatic logic vtx_use_end(input logic [2:0] k);
		return (k == 3'd2) || (k == 3'd3) || (k == 3'd5);
	endfunction

	function automatic logic vtx_plus(input logic [2:0] k);
		return (k == 3'd0) || (k == 3'd3) || (k == 3'd4);
	endfunction

endpackage
`default_nettype wire

/* rtl/thick_line_quad_expander.sv */
`default_nettype none
// Path from segment in to first vertex out: front registers, queue, square root, multiply,
// divide, output register; a zero-length segment skips root and divide.
// The back end takes the next segment only once the current one has left, after its
// bit-serial square root (32 steps), a restoring divider for both components and six emits.
// Six vertices per segment leave at one per cycle when out_ready stays high.
// Reset: arst_n clears all control state; line_width returns to 256 (1.0 px).
module thick_line_quad_expander #(
	parameter int COORD_BITS = 24,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic                  [15:0] cfg_wr_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [COORD_BITS-1:0] start_x,
	input  wire logic signed [COORD_BITS-1:0] start_y,
	input  wire logic signed [COORD_BITS-1:0] end_x,
	input  wire logic signed [COORD_BITS-1:0] end_y,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed      [COORD_BITS-1:0] vertex_x,
	output logic signed      [COORD_BITS-1:0] vertex_y,
	output logic                        [2:0] vertex_index,
	output logic                              last_vertex,
	output logic                              degenerate,
	output logic                              clamped
);
	import tlq_pkg::*;

	// queue entry: endpoints, normalized |d| components, their squares, flags
	localparam int ENTRY_BITS = 4 * COORD_BITS + 2 * NORM_BITS + 2 * SQ_BITS + 3;

	logic [15:0]           line_width_q;
	logic                  push, pop, q_full, q_valid;
	logic [ENTRY_BITS-1:0] push_data, q_data;

	// line width register, Q8.8 pixels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= 16'd256;
		end else if (cfg_wr_en) begin
			line_width_q <= cfg_wr_data;
		end
	end

	// front: difference, abs, range normalize, squares
	tlq_front #(.COORD_BITS(COORD_BITS), .ENTRY_BITS(ENTRY_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready,
		.start_x, .start_y, .end_x, .end_y,
		.push, .push_data, .q_full
	);

	// decouples the front from the long back-end iteration
	tlq_fifo #(.WIDTH(ENTRY_BITS)) u_fifo (
		.clk, .arst_n,
		.wr_en(push), .wr_data(push_data), .full(q_full),
		.rd_en(pop), .rd_data(q_data), .not_empty(q_valid)
	);

	// back: sqrt, divide, vertex emit through output register
	tlq_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .ENTRY_BITS(ENTRY_BITS)) u_back (
		.clk, .arst_n, .line_width(line_width_q),
		.q_valid, .q_data, .pop,
		.out_valid, .out_ready,
		.vertex_x, .vertex_y, .vertex_index, .last_vertex, .degenerate, .clamped
	);
endmodule
`default_nettype wire

/* rtl/tlq_fifo.sv */
`default_nettype none
module tlq_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  not_empty
);
	// two-entry queue
	logic [WIDTH-1:0] mem [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign rd_data   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= ~wr_ptr_q;
			if (rd_en) rd_ptr_q <= ~rd_ptr_q;
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/tlq_front.sv */
`default_nettype none
module tlq_front #(
	parameter int COORD_BITS = 24,
	parameter int ENTRY_BITS = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [COORD_BITS-1:0] start_x,
	input  wire logic signed [COORD_BITS-1:0] start_y,
	input  wire logic signed [COORD_BITS-1:0] end_x,
	input  wire logic signed [COORD_BITS-1:0] end_y,
	output logic                              push,
	output logic             [ENTRY_BITS-1:0] push_data,
	input  wire logic                         q_full
);
	import tlq_pkg::*;

	localparam int AW = COORD_BITS + 1;
	localparam int MW = (AW > NORM_BITS) ? AW : NORM_BITS;

	logic signed [AW-1:0] dx, dy;
	logic [AW-1:0]        ax, ay, amax;
	logic [MW-1:0]        axe, aye;
	logic [4:0]           sh;

	logic                  v_s1, v_s2;
	logic [COORD_BITS-1:0] x1_s1, y1_s1, x2_s1, y2_s1;
	logic [COORD_BITS-1:0] x1_s2, y1_s2, x2_s2, y2_s2;
	logic [NORM_BITS-1:0]  ax_s1, ay_s1, ax_s2, ay_s2;
	logic [SQ_BITS-1:0]    sqx_s2, sqy_s2;
	tlq_flags_t            fl_s1, fl_s2;
	logic                  adv2;

	always_comb begin
		dx   = AW'(end_x) - AW'(start_x);
		dy   = AW'(end_y) - AW'(start_y);
		ax   = dx[AW-1] ? AW'(-dx) : AW'(dx);
		ay   = dy[AW-1] ? AW'(-dy) : AW'(dy);
		amax = (ax > ay) ? ax : ay;
		sh   = 5'd0;
		for (int i = NORM_BITS; i < AW; i++) begin
			if (amax[i]) sh = 5'(i - NORM_BITS + 1);
		end
		axe = MW'(ax) >> sh;
		aye = MW'(ay) >> sh;
	end

	assign push     = v_s2 && !q_full;
	assign adv2     = !v_s2 || push;
	assign in_ready = !v_s1 || adv2;
	assign push_data = {x1_s2, y1_s2, x2_s2, y2_s2, ax_s2, ay_s2, sqx_s2, sqy_s2, fl_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (adv2)     v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x1_s1        <= start_x;
			y1_s1        <= start_y;
			x2_s1        <= end_x;
			y2_s1        <= end_y;
			ax_s1        <= NORM_BITS'(axe);
			ay_s1        <= NORM_BITS'(aye);
			fl_s1.degen  <= (ax == '0) && (ay == '0);
			fl_s1.dx_neg <= dx[AW-1];
			fl_s1.dy_neg <= dy[AW-1];
		end
		if (adv2 && v_s1) begin
			x1_s2  <= x1_s1;
			y1_s2  <= y1_s1;
			x2_s2  <= x2_s1;
			y2_s2  <= y2_s1;
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			sqx_s2 <= ax_s1 * ax_s1;
			sqy_s2 <= ay_s1 * ay_s1;
			fl_s2  <= fl_s1;
		end
	end
endmodule
`default_nettype wire

/* rtl/tlq_back.sv */
`default_nettype none
module tlq_back #(
	parameter int COORD_BITS = 24,
	parameter int FRAC_BITS  = 8,
	parameter int ENTRY_BITS = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                  [15:0] line_width,
	input  wire logic                         q_valid,
	input  wire logic        [ENTRY_BITS-1:0] q_data,
	output logic                              pop,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed      [COORD_BITS-1:0] vertex_x,
	output logic signed      [COORD_BITS-1:0] vertex_y,
	output logic                        [2:0] vertex_index,
	output logic                              last_vertex,
	output logic                              degenerate,
	output logic                              clamped
);
	import tlq_pkg::*;

	localparam int QB   = FRAC_BITS + QUOT_XTRA;
	localparam int NUMW = NORM_BITS + 16 + FRAC_BITS + 1;
	localparam int DENW = ROOT_BITS + 2;
	localparam int CMPW = (NUMW > DENW + QB) ? NUMW : DENW + QB;
	localparam int REMW = ROOT_BITS + 2;
	localparam int SW   = COORD_BITS + QB + 2;
	localparam int CNTW = 5;
	localparam logic [CNTW-1:0] SQRT_LAST = CNTW'(ROOT_BITS - 1);
	localparam logic [CNTW-1:0] DIV_LAST  = CNTW'(QB - 1);

	typedef enum logic [2:0] {S_IDLE, S_SQRT, S_MUL, S_DIV, S_EMIT} state_t;

	state_t                 state_q;
	logic [CNTW-1:0]        cnt_q;
	logic [2:0]             k_q;
	logic [COORD_BITS-1:0]  x1_q, y1_q, x2_q, y2_q;
	logic [NORM_BITS-1:0]   ax_q, ay_q;
	tlq_flags_t             fl_q;
	logic [RAD_BITS-1:0]    rad_q;
	logic [REMW-1:0]        srem_q;
	logic [ROOT_BITS-1:0]   root_q;
	logic [CMPW-1:0]        remx_q, remy_q, dsh_q;
	logic [QB-1:0]          qx_q, qy_q;

	// queue entry fields
	logic [COORD_BITS-1:0]  e_x1, e_y1, e_x2, e_y2;
	logic [NORM_BITS-1:0]   e_ax, e_ay;
	logic [SQ_BITS-1:0]     e_sqx, e_sqy;
	tlq_flags_t             e_fl;

	assign {e_x1, e_y1, e_x2, e_y2, e_ax, e_ay, e_sqx, e_sqy, e_fl} = q_data;

	// square root step: two radicand bits in, one root bit out
	logic [REMW-1:0] srem_sh, strial, srem_n;
	logic [ROOT_BITS-1:0] root_n;
	always_comb begin
		srem_sh = {srem_q[REMW-3:0], rad_q[RAD_BITS-1 -: 2]};
		strial  = {root_q, 2'b01};
		if (srem_sh >= strial) begin
			srem_n = srem_sh - strial;
			root_n = {root_q[ROOT_BITS-2:0], 1'b1};
		end else begin
			srem_n = srem_sh;
			root_n = {root_q[ROOT_BITS-2:0], 1'b0};
		end
	end

	// numerators: a * line_width * 2^FRAC_BITS + 2L (den / 2 with den = 4L)
	logic [NUMW-1:0] scale, numx, numy;
	always_comb begin
		scale = NUMW'(line_width) << FRAC_BITS;
		numx  = NUMW'(ax_q) * scale + (NUMW'(root_q) << 1);
		numy  = NUMW'(ay_q) * scale + (NUMW'(root_q) << 1);
	end

	// vertex build
	logic signed [QB:0]           nx, ny, nxs, nys;
	logic signed [SW-1:0]         sx, sy, bx, by;
	logic signed [COORD_BITS-1:0] vx, vy;
	logic                         hitx, hity;
	localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] LO = -HI - SW'(1);
	always_comb begin
		nx  = fl_q.dy_neg ? $signed({1'b0, qy_q}) : -$signed({1'b0, qy_q});
		ny  = fl_q.dx_neg ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
		nxs = vtx_plus(k_q) ? nx : -nx;
		nys = vtx_plus(k_q) ? ny : -ny;
		bx  = SW'($signed(vtx_use_end(k_q) ? x2_q : x1_q));
		by  = SW'($signed(vtx_use_end(k_q) ? y2_q : y1_q));
		sx  = bx + SW'(nxs);
		sy  = by + SW'(nys);
		hitx = (sx > HI) || (sx < LO);
		hity = (sy > HI) || (sy < LO);
		vx  = (sx > HI) ? COORD_BITS'(HI) : (sx < LO) ? COORD_BITS'(LO) : COORD_BITS'(sx);
		vy  = (sy > HI) ? COORD_BITS'(HI) : (sy < LO) ? COORD_BITS'(LO) : COORD_BITS'(sy);
	end

	logic emit;
	assign pop  = (state_q == S_IDLE) && q_valid;
	assign emit = (state_q == S_EMIT) && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			k_q          <= VIDX_FIRST;
			out_valid    <= 1'b0;
			vertex_x     <= '0;
			vertex_y     <= '0;
			vertex_index <= VIDX_FIRST;
			last_vertex  <= 1'b0;
			degenerate   <= 1'b0;
			clamped      <= 1'b0;
		end else begin
			out_valid <= emit || (out_valid && !out_ready);
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cnt_q   <= '0;
						k_q     <= VIDX_FIRST;
						state_q <= e_fl.degen ? S_EMIT : S_SQRT;
					end
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SQRT_LAST) state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit) begin
						vertex_x     <= vx;
						vertex_y     <= vy;
						vertex_index <= k_q;
						last_vertex  <= (k_q == VIDX_LAST);
						degenerate   <= fl_q.degen;
						clamped      <= hitx || hity;
						k_q          <= k_q + 3'd1;
						if (k_q == VIDX_LAST) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x1_q   <= e_x1;
			y1_q   <= e_y1;
			x2_q   <= e_x2;
			y2_q   <= e_y2;
			ax_q   <= e_ax;
			ay_q   <= e_ay;
			fl_q   <= e_fl;
			rad_q  <= RAD_BITS'(e_sqx + e_sqy) << RAD_SHIFT;
			srem_q <= '0;
			root_q <= '0;
			qx_q   <= '0;
			qy_q   <= '0;
		end
		if (state_q == S_SQRT) begin
			rad_q  <= rad_q << 2;
			srem_q <= srem_n;
			root_q <= root_n;
		end
		if (state_q == S_MUL) begin
			remx_q <= CMPW'(numx);
			remy_q <= CMPW'(numy);
			dsh_q  <= CMPW'({root_q, 2'b00}) << (QB - 1);
		end
		if (state_q == S_DIV) begin
			dsh_q <= dsh_q >> 1;
			if (remx_q >= dsh_q) begin
				remx_q <= remx_q - dsh_q;
				qx_q   <= {qx_q[QB-2:0], 1'b1};
			end else begin
				qx_q   <= {qx_q[QB-2:0], 1'b0};
			end
			if (remy_q >= dsh_q) begin
				remy_q <= remy_q - dsh_q;
				qy_q   <= {qy_q[QB-2:0], 1'b1};
			end else begin
				qy_q   <= {qy_q[QB-2:0], 1'b0};
			end
		end
	end

`ifndef SYNTHESIS
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_vertex |-> vertex_index == VIDX_LAST)
		else $error("last flag off the final vertex");
	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |=> state_q == S_DIV || state_q == S_EMIT)
		else $error("divider left early");
	a_emit_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && k_q != VIDX_LAST |=> !pop)
		else $error("queue popped mid-emit");
`endif
endmodule
`default_nettype wire

/* test/thick_line_quad_expander_tb.sv */
`default_nettype none
module thick_line_quad_expander_tb;
	import tlq_pkg::*;

	localparam int CB = 24;
	localparam int FB = 8;

	// one vertex as it leaves the block
	typedef struct packed {
		logic signed [CB-1:0] vx;
		logic signed [CB-1:0] vy;
		logic [2:0]           vidx;
		logic                 last;
		logic                 degen;
		logic                 clamp;
	} vertex_t;

	// directed segment; has_exp marks rows whose vertex 0 is typed in
	typedef struct {
		logic signed [CB-1:0] sx, sy, ex, ey;
		bit                   has_exp;
		vertex_t              v0;
	} seg_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CB-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [CB-1:0] vertex_x, vertex_y;
	logic [2:0] vertex_index;
	logic last_vertex, degenerate, clamped;

	vertex_t vertex_q[$];
	int errors = 0;
	logic [15:0] width_reg;
	bit calm = 0;     // no idling near the end
	bit sink_on = 0;
	int stall_left = 0;

	always #5 clk = ~clk;

	thick_line_quad_expander #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_index(vertex_index),
		.last_vertex(last_vertex), .degenerate(degenerate), .clamped(clamped)
	);

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	// integer square root, bit by bit
	function automatic logic [63:0] root64(input logic [63:0] v);
		logic [63:0] res, b;
		res = '0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint clamp_coord(input longint v, inout logic hit);
		longint hi, lo;
		hi = (64'sd1 <<< (CB - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			hit = 1'b1;
			return hi;
		end
		if (v < lo) begin
			hit = 1'b1;
			return lo;
		end
		return v;
	endfunction

	// builds the six quad vertices of one segment
	task automatic expand_segment(input logic signed [CB-1:0] sx, sy, ex, ey);
		longint x1, y1, x2, y2, dx, dy, nx, ny, bx, by, tx, ty;
		logic [63:0] ax, ay, len, den, scale, qx, qy;
		logic degen, hit, use_end, plus;
		vertex_t v;
		x1 = longint'(sx); y1 = longint'(sy); x2 = longint'(ex); y2 = longint'(ey);
		dx = x2 - x1; dy = y2 - y1;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		degen = (ax == 0 && ay == 0);
		nx = 0; ny = 0;
		if (!degen) begin
			while (ax >= (64'd1 << NORM_BITS) || ay >= (64'd1 << NORM_BITS)) begin
				ax >>= 1;
				ay >>= 1;
			end
			len = root64((ax * ax + ay * ay) << 14);
			den = 64'd4 * len;
			scale = 64'(width_reg) << FB;
			qy = (ay * scale + den / 2) / den;
			qx = (ax * scale + den / 2) / den;
			nx = dy < 0 ? longint'(qy) : -longint'(qy);
			ny = dx < 0 ? -longint'(qx) : longint'(qx);
		end
		for (int k = 0; k < 6; k++) begin
			use_end = vtx_use_end(3'(k));
			plus = vtx_plus(3'(k));
			bx = use_end ? x2 : x1;
			by = use_end ? y2 : y1;
			hit = 1'b0;
			tx = clamp_coord(plus ? bx + nx : bx - nx, hit);
			ty = clamp_coord(plus ? by + ny : by - ny, hit);
			v.vx = tx[CB-1:0];
			v.vy = ty[CB-1:0];
			v.vidx = 3'(k);
			v.last = (3'(k) == VIDX_LAST);
			v.degen = degen;
			v.clamp = hit;
			vertex_q.insert(vertex_q.size(), v);
		end
	endtask

	// in_valid stays high across back-to-back items and drops only for a gap
	task automatic send_segment(input logic signed [CB-1:0] sx, sy, ex, ey);
		int gap;
		if (!calm && $urandom_range(3) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		expand_segment(sx, sy, ex, ey);
		start_x <= sx; start_y <= sy; end_x <= ex; end_y <= ey;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_width(input logic [15:0] w);
		// block must be idle: nothing pending, latency margin passed
		in_valid <= 1'b0;
		wait (vertex_q.size() == 0);
		repeat (80) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= w;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		width_reg = w;
	endtask

	// random segment; mostly short, some zero length, some between random endpoints
	task automatic random_segment();
		logic signed [CB-1:0] sx, sy, ex, ey;
		sx = CB'($urandom); sy = CB'($urandom);
		case ($urandom_range(4))
			0: begin
				ex = CB'($urandom);
				ey = CB'($urandom);
			end
			1: begin
				ex = sx;
				ey = sy;
			end
			2: begin
				ex = sx + $signed(24'($urandom_range(0, 8191)) - 24'sd4096);
				ey = sy;
			end
			default: begin
				ex = sx + $signed(24'($urandom_range(0, 65535)) - 24'sd32768);
				ey = sy + $signed(24'($urandom_range(0, 65535)) - 24'sd32768);
			end
		endcase
		send_segment(sx, sy, ex, ey);
	endtask

	// output sink with random stall bursts
	always @(posedge clk) begin
		if (!sink_on) begin
			out_ready <= 1'b0;
		end else if (calm) begin
			out_ready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= (stall_left == 1);
		end else if (out_ready && $urandom_range(3) == 0) begin
			stall_left <= $urandom_range(1, 8);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// check every accepted vertex against the oldest expectation
	always @(posedge clk) begin
		vertex_t e;
		if (arst_n && out_valid && out_ready) begin
			if (vertex_q.size() == 0) begin
				report("vertex with nothing expected");
			end else begin
				e = vertex_q.pop_front();
				if (vertex_x !== e.vx)
					report($sformatf("vertex_x %0d exp %0d", vertex_x, e.vx));
				if (vertex_y !== e.vy)
					report($sformatf("vertex_y %0d exp %0d", vertex_y, e.vy));
				if (vertex_index !== e.vidx)
					report($sformatf("vertex_index %0d exp %0d", vertex_index, e.vidx));
				if (last_vertex !== e.last)
					report($sformatf("last_vertex %0b exp %0b", last_vertex, e.last));
				if (degenerate !== e.degen)
					report($sformatf("degenerate %0b exp %0b", degenerate, e.degen));
				if (clamped !== e.clamp)
					report($sformatf("clamped %0b exp %0b", clamped, e.clamp));
			end
		end
	end

	seg_row_t rows[$];

	function automatic seg_row_t row(input int sx, sy, ex, ey, input bit he = 0,
		input int vx = 0, vy = 0, input bit dg = 0, input bit cl = 0);
		seg_row_t r;
		r.sx = CB'(sx); r.sy = CB'(sy); r.ex = CB'(ex); r.ey = CB'(ey);
		r.has_exp = he;
		r.v0.vx = CB'(vx); r.v0.vy = CB'(vy); r.v0.vidx = VIDX_FIRST;
		r.v0.last = 1'b0; r.v0.degen = dg; r.v0.clamp = cl;
		return r;
	endfunction

	localparam int CMAX = 8388607;
	localparam int CMIN = -8388608;

	initial begin
		int n;
		width_reg = 16'd256;
		// typed rows at width 1.0: |n| = 0.5 px = 128 raw
		rows.insert(rows.size(), row(0, 0, 0, 0, 1, 0, 0, 1, 0));          // zero length
		rows.insert(rows.size(), row(0, 0, 2560, 0, 1, 0, 128, 0, 0));     // along +x
		rows.insert(rows.size(), row(0, 0, 0, 2560, 1, -128, 0, 0, 0));    // along +y
		rows.insert(rows.size(), row(0, 0, -2560, 0, 1, 0, -128, 0, 0));   // along -x
		// full span; the first of these clamps
		rows.insert(rows.size(), row(CMIN, CMAX, CMAX, CMAX, 1, CMIN, CMAX, 0, 1));
		rows.insert(rows.size(), row(CMAX, CMIN, CMAX, CMAX, 1, CMAX - 128, CMIN, 0, 0));
		// degenerate at the limits
		rows.insert(rows.size(), row(CMAX, CMAX, CMAX, CMAX, 1, CMAX, CMAX, 1, 0));
		rows.insert(rows.size(), row(CMIN, CMIN, CMIN, CMIN, 1, CMIN, CMIN, 1, 0));
		rows.insert(rows.size(), row(CMIN, CMIN, CMAX, CMAX));     // diagonal, all bits
		rows.insert(rows.size(), row(CMAX, CMIN, CMIN, CMAX));
		rows.insert(rows.size(), row(0, 0, 1, 0));                 // shortest
		rows.insert(rows.size(), row(0, 0, 1, -1));
		rows.insert(rows.size(), row(100, 200, -300, 400));
		rows.insert(rows.size(), row(-5, -5, -5, 5));
		rows.insert(rows.size(), row(CMAX, 0, CMAX - 1, 0));
		rows.insert(rows.size(), row(CMIN, 0, CMIN, 1));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sink_on = 1;

		foreach (rows[i]) begin
			if (rows[i].has_exp) begin
				// spot check vertex 0 against the typed value as well
				n = vertex_q.size();
				expand_segment(rows[i].sx, rows[i].sy, rows[i].ex, rows[i].ey);
				if (vertex_q[n] !== rows[i].v0)
					report($sformatf("directed row %0d: predicted vertex 0 differs", i));
				repeat (6) void'(vertex_q.pop_back());
			end
			send_segment(rows[i].sx, rows[i].sy, rows[i].ex, rows[i].ey);
		end

		// width sweep: min, max, two patterned values, then a random value
		write_width(16'd0);
		send_segment(CB'(0), CB'(0), CB'(2560), CB'(0));
		send_segment(CB'(CMIN), CB'(CMIN), CB'(CMAX), CB'(CMAX));
		for (int i = 0; i < 10; i++) random_segment();
		write_width(16'hFFFF);
		send_segment(CB'(0), CB'(0), CB'(2560), CB'(0));
		send_segment(CB'(CMAX - 10), CB'(0), CB'(CMAX - 10), CB'(2560));
		for (int i = 0; i < 15; i++) random_segment();
		write_width(16'h5555);
		for (int i = 0; i < 20; i++) random_segment();
		write_width(16'hAAAA);
		for (int i = 0; i < 20; i++) random_segment();
		write_width(16'($urandom));
		for (int i = 0; i < 20; i++) random_segment();
		calm = 1;
		for (int i = 0; i < 15; i++) random_segment();
		in_valid <= 1'b0;

		fork
			wait (vertex_q.size() == 0);
			repeat (20000) @(posedge clk);
		join_any
		disable fork;
		repeat (80) @(posedge clk);
		if (errors == 0 && vertex_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// hard limit: room for ~120 items with input gaps and output stalls, many times over
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire

/* files.f */
rtl/tlq_pkg.sv
rtl/tlq_fifo.sv
rtl/tlq_front.sv
rtl/tlq_back.sv
rtl/thick_line_quad_expander.sv
test/thick_line_quad_expander_tb.sv
